// ===== rtl/gcsm_pkg.sv =====
// shared types and constants for the glyph cache slot manager
package gcsm_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int CODE_W         = 16;
    localparam int STATUS_W       = 3;
    localparam int SLOT_IDX_W     = 6;

    typedef enum logic [1:0] {
        OP_LOOKUP      = 2'd0,
        OP_BEGIN_FRAME = 2'd1,
        OP_EVICT       = 2'd2,
        OP_RESET       = 2'd3
    } gcsm_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT         = 3'd0,
        STAT_FILLED      = 3'd1,
        STAT_NOT_IN_FONT = 3'd2,
        STAT_FULL        = 3'd3,
        STAT_MAINT       = 3'd4
    } gcsm_status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } gcsm_state_t;

    typedef struct packed {
        gcsm_op_t            opcode;
        logic [CODE_W-1:0]   glyph_code;
        logic                glyph_in_font;
    } gcsm_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_index;
    } gcsm_rsp_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              mark;
    } gcsm_entry_t;

endpackage

// ===== rtl/gcsm_slot_ram.sv =====
// slot table memory with per-entry valid bits so cleared entries read as empty
module gcsm_slot_ram
    import gcsm_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IW        = $clog2(SLOT_COUNT)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clr_all,
    input  logic        rd_en,
    input  logic [IW-1:0] rd_addr,
    output gcsm_entry_t rd_data,
    input  logic        wr_en,
    input  logic [IW-1:0] wr_addr,
    input  gcsm_entry_t wr_data
);

    gcsm_entry_t            slot_mem [SLOT_COUNT];
    gcsm_entry_t            rd_data_reg;
    logic                   rd_vld_reg;
    logic [SLOT_COUNT-1:0]  vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr_all)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // entries never written since the last clear read as empty
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/glyph_cache_slot_manager.sv =====
// top level of the glyph cache slot manager: scan sequencer around the slot memory
// reset table finishes without a scan; a lookup hit stops at the matching slot; a miss, begin frame
//   and evict unused scan every slot (one memory read per slot, pipelined)
// throughput: one beat at a time; busy is high during the scan and a new beat
//   may start in the cycle the result strobe is shown
// reset: asynchronous, clears all valid bits so the whole table reads as empty
// the receiver cannot stall: done is high for exactly one cycle per beat
module glyph_cache_slot_manager
    import gcsm_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  gcsm_req_t req,
    output logic      done,
    output gcsm_rsp_t rsp
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // sequencer state
    gcsm_state_t        state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;        // next slot to read
    logic               rd_pend_reg;              // read data valid this cycle
    logic [IW-1:0]      rd_idx_reg;               // slot that read data belongs to

    // latched request
    gcsm_op_t           op_reg, op_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               in_font_reg, in_font_next;

    // lowest empty slot seen so far during a lookup scan
    logic               empty_found_reg, empty_found_next;
    logic [IW-1:0]      empty_idx_reg, empty_idx_next;

    // result register
    logic               done_reg, done_next;
    gcsm_rsp_t          rsp_reg, rsp_next;

    // memory port signals
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    gcsm_entry_t        ent;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    gcsm_entry_t        wr_data;
    logic               clr_all;

    // scan decode
    logic               last_slot;
    logic               ent_empty;
    logic [IW-1:0]      fill_idx;

    gcsm_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr_all (clr_all),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ent),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // one read per cycle walks the table from slot zero
    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg < CW'(SLOT_COUNT));
    assign rd_addr = cnt_reg[IW-1:0];

    assign last_slot = (rd_idx_reg == IW'(SLOT_COUNT - 1));
    assign ent_empty = (ent.code == '0) && !ent.mark;
    // the current slot may be the first empty one
    assign fill_idx  = empty_found_reg ? empty_idx_reg : rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            empty_found_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            rd_pend_reg     <= rd_en;
            empty_found_reg <= empty_found_next;
            done_reg        <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_addr;
        op_reg        <= op_next;
        code_reg      <= code_next;
        in_font_reg   <= in_font_next;
        empty_idx_reg <= empty_idx_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        op_next          = op_reg;
        code_next        = code_reg;
        in_font_next     = in_font_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;
        wr_en            = 1'b0;
        wr_addr          = rd_idx_reg;
        wr_data          = ent;
        clr_all          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next          = req.opcode;
                    code_next        = req.glyph_code;
                    in_font_next     = req.glyph_in_font;
                    cnt_next         = '0;
                    empty_found_next = 1'b0;
                    if (req.opcode == OP_RESET)
                    begin
                        // whole table drops out at once through the valid bits
                        clr_all             = 1'b1;
                        done_next           = 1'b1;
                        rsp_next.status     = STAT_MAINT;
                        rsp_next.slot_index = '0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (rd_pend_reg)
                begin
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            if (ent.code == code_reg)
                            begin
                                // lowest match wins: mark it and stop
                                wr_en               = 1'b1;
                                wr_data.code        = ent.code;
                                wr_data.mark        = 1'b1;
                                state_next          = ST_IDLE;
                                done_next           = 1'b1;
                                rsp_next.status     = STAT_HIT;
                                rsp_next.slot_index = SLOT_IDX_W'(rd_idx_reg);
                            end
                            else
                            begin
                                if (ent_empty && !empty_found_reg)
                                begin
                                    empty_found_next = 1'b1;
                                    empty_idx_next   = rd_idx_reg;
                                end
                                if (last_slot)
                                begin
                                    state_next          = ST_IDLE;
                                    done_next           = 1'b1;
                                    rsp_next.slot_index = '0;
                                    if (!in_font_reg)
                                    begin
                                        rsp_next.status = STAT_NOT_IN_FONT;
                                    end
                                    else if (empty_found_reg || ent_empty)
                                    begin
                                        wr_en               = 1'b1;
                                        wr_addr             = fill_idx;
                                        wr_data.code        = code_reg;
                                        wr_data.mark        = 1'b1;
                                        rsp_next.status     = STAT_FILLED;
                                        rsp_next.slot_index = SLOT_IDX_W'(fill_idx);
                                    end
                                    else
                                    begin
                                        rsp_next.status = STAT_FULL;
                                    end
                                end
                            end
                        end

                        OP_BEGIN_FRAME:
                        begin
                            wr_en        = 1'b1;
                            wr_data.code = ent.code;
                            wr_data.mark = 1'b0;
                        end

                        OP_EVICT:
                        begin
                            // unmarked slots lose their code
                            wr_en        = 1'b1;
                            wr_data.code = ent.mark ? ent.code : '0;
                            wr_data.mark = ent.mark;
                        end

                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase

                    if ((op_reg != OP_LOOKUP) && last_slot)
                    begin
                        state_next          = ST_IDLE;
                        done_next           = 1'b1;
                        rsp_next.status     = STAT_MAINT;
                        rsp_next.slot_index = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    // a result beat is only shown once the scan has released the block
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // every accepted beat either finishes at once or starts a scan
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted beat neither done nor scanning");

    // only hits and fills carry a slot number
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != STAT_HIT) && (rsp.status != STAT_FILLED))
            |-> (rsp.slot_index == '0))
        else $error("nonzero slot index on non-slot status");

    // no more than one result per accepted beat
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done || $past(start && !busy))
        else $error("repeated result strobe");
`endif

endmodule
